/* src/qved_pkg.sv */
// ----------------------------------------------------------------------------
// qved_pkg
// Shared codes, widths and helpers for the query value extract/decode block.
// ----------------------------------------------------------------------------
package qved_pkg;

	// Fixed field and register widths
	localparam int BYTE_W     = 8;
	localparam int STATUS_W   = 2;
	localparam int KEYLEN_W   = 5;
	localparam int KEYWORD_W  = 64;
	localparam int CFG_IDX_W  = 2;
	localparam int KEY_CHARS  = 16;
	localparam int KEY_MAX_DEF = 16;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH   = 2'd2;

	// Scan phases
	localparam int PHASE_W = 3;
	localparam logic [PHASE_W-1:0] PH_SEARCH = 3'd0;
	localparam logic [PHASE_W-1:0] PH_VALUE  = 3'd1;
	localparam logic [PHASE_W-1:0] PH_ESC1   = 3'd2;
	localparam logic [PHASE_W-1:0] PH_ESC2   = 3'd3;
	localparam logic [PHASE_W-1:0] PH_DONE   = 3'd4;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_BYTE     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_COMPLETE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOKEY    = 2'd2;
	localparam logic [STATUS_W-1:0] ST_TRUNC    = 2'd3;

	// Special characters
	localparam logic [BYTE_W-1:0] CH_PLUS    = 8'h2B;
	localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;
	localparam logic [BYTE_W-1:0] CH_PERCENT = 8'h25;
	localparam logic [BYTE_W-1:0] CH_EQUAL   = 8'h3D;
	localparam logic [BYTE_W-1:0] CH_AMP     = 8'h26;

	// One result item
	typedef struct packed {
		logic [BYTE_W-1:0]   data;
		logic [STATUS_W-1:0] status;
		logic                last;
	} result_t;

	// Hex digit to nibble; anything else counts as zero
	function automatic logic [3:0] nibble_of(input logic [BYTE_W-1:0] c);
		logic [3:0] n;
		n = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			n = 4'(c - 8'h30);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			n = 4'(c - 8'h57);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			n = 4'(c - 8'h37);
		end
		return n;
	endfunction

endpackage

/* src/query_value_extract_decode.sv */
// ----------------------------------------------------------------------------
// query_value_extract_decode
// Finds "key=" in a query string and emits the percent-decoded value.
// ----------------------------------------------------------------------------
// The block takes one query string character per cycle on the slave stream
// (s_tlast marks the final character) and compares a sliding window of the
// last KEY_MAX characters against the configured key in the same cycle that
// the character is accepted. Each character yields zero, one or two results,
// which go into a four-entry result queue; the master stream drains one result
// per cycle while m_tready is high. s_tready stays high while at least two queue
// entries are free, so a character is taken every cycle as long as the consumer
// keeps up; only the final value byte of a string gives two results. Key
// registers take effect on the next character.
// ----------------------------------------------------------------------------
module query_value_extract_decode #(
	parameter int KEY_MAX = qved_pkg::KEY_MAX_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration write port
	input  logic                           cfg_we,
	input  logic [qved_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [qved_pkg::KEYWORD_W-1:0] cfg_wdata,
	// query string input
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [7:0]                     s_tdata,   // [7:0] in_byte
	input  logic                           s_tlast,   // end_of_string
	// result output
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [7:0]                     m_tdata,   // [7:0] out_byte
	output logic [1:0]                     m_tuser,   // [1:0] status
	output logic                           m_tlast    // last
);
	import qved_pkg::*;

	localparam int LEN_W   = $clog2(KEY_MAX + 1);
	localparam int Q_DEPTH = 4;
	localparam int QPTR_W  = 2;
	localparam int QCNT_W  = 3;

	// Configuration registers
	logic [KEYLEN_W-1:0]  key_len_q;
	logic [KEYWORD_W-1:0] key_low_q;
	logic [KEYWORD_W-1:0] key_high_q;

	// Stream state
	logic [BYTE_W-1:0]  win_q [KEY_MAX];
	logic [PHASE_W-1:0] phase_q;
	logic [3:0]         hi_nib_q;
	logic [LEN_W-1:0]   seen_q;

	// Result queue
	result_t            q_mem [Q_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  cnt_q;

	logic               in_xfer;
	logic               out_xfer;
	logic [BYTE_W-1:0]  key_chr [KEY_CHARS];
	logic [KEY_MAX:0]   match_len;
	logic [LEN_W-1:0]   len_eff;
	logic               key_hit;
	logic [BYTE_W-1:0]  plain_byte;
	logic [BYTE_W-1:0]  esc_byte;

	logic [PHASE_W-1:0] phase_d;
	logic [3:0]         hi_nib_d;
	logic               push;
	logic               res_a_vld;
	logic               res_b_vld;
	result_t            res_a;
	result_t            res_b;
	logic [1:0]         n_wr;

	assign in_xfer  = s_tvalid && s_tready;
	assign out_xfer = m_tvalid && m_tready;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_len_q  <= KEYLEN_W'(1);
			key_low_q  <= '0;
			key_high_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_KEY_LENGTH: key_len_q  <= cfg_wdata[KEYLEN_W-1:0];
				REG_KEY_LOW:    key_low_q  <= cfg_wdata;
				REG_KEY_HIGH:   key_high_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Split key words into characters
	always_comb begin
		for (int i = 0; i < KEY_CHARS / 2; i++) begin
			key_chr[i]                 = key_low_q[BYTE_W*i +: BYTE_W];
			key_chr[i + KEY_CHARS / 2] = key_high_q[BYTE_W*i +: BYTE_W];
		end
	end

	// Saturate key length
	assign len_eff = (key_len_q > KEYLEN_W'(KEY_MAX)) ? LEN_W'(KEY_MAX)
	                                                  : LEN_W'(key_len_q);

	// Compare window against key for every possible length; newest byte ends the key
	always_comb begin
		match_len[0] = 1'b1;
		for (int l = 1; l <= KEY_MAX; l++) begin
			match_len[l] = 1'b1;
			for (int j = 0; j < l; j++) begin
				if (win_q[j] != key_chr[l - 1 - j]) begin
					match_len[l] = 1'b0;
				end
			end
		end
	end

	assign key_hit = (seen_q >= len_eff) && match_len[len_eff];

	assign plain_byte = (s_tdata == CH_PLUS) ? CH_SPACE : s_tdata;
	assign esc_byte   = {hi_nib_q, nibble_of(s_tdata)};

	// Decide next phase and the results of this character
	always_comb begin
		phase_d   = phase_q;
		hi_nib_d  = hi_nib_q;
		push      = 1'b0;
		res_a_vld = 1'b0;
		res_b_vld = 1'b0;
		res_a     = '{data: '0, status: ST_COMPLETE, last: 1'b1};
		res_b     = '{data: '0, status: ST_COMPLETE, last: 1'b1};
		unique case (phase_q)
			PH_SEARCH: begin
				if (s_tdata == CH_EQUAL && key_hit) begin
					phase_d   = PH_VALUE;
					res_a_vld = s_tlast;
				end else begin
					push         = 1'b1;
					res_a_vld    = s_tlast;
					res_a.status = ST_NOKEY;
				end
			end
			PH_VALUE: begin
				if (s_tdata == CH_AMP) begin
					res_a_vld = 1'b1;
					phase_d   = PH_DONE;
				end else if (s_tdata == CH_PERCENT) begin
					phase_d      = PH_ESC1;
					res_a_vld    = s_tlast;
					res_a.status = ST_TRUNC;
				end else begin
					res_a_vld = 1'b1;
					res_a     = '{data: plain_byte, status: ST_BYTE, last: 1'b0};
					res_b_vld = s_tlast;
				end
			end
			PH_ESC1: begin
				res_a.status = ST_TRUNC;
				if (s_tdata == CH_AMP) begin
					res_a_vld = 1'b1;
					phase_d   = PH_DONE;
				end else begin
					hi_nib_d  = nibble_of(s_tdata);
					phase_d   = PH_ESC2;
					res_a_vld = s_tlast;
				end
			end
			PH_ESC2: begin
				if (s_tdata == CH_AMP) begin
					res_a_vld    = 1'b1;
					res_a.status = ST_TRUNC;
					phase_d      = PH_DONE;
				end else begin
					res_a_vld = 1'b1;
					res_a     = '{data: esc_byte, status: ST_BYTE, last: 1'b0};
					phase_d   = PH_VALUE;
					res_b_vld = s_tlast;
				end
			end
			default: ;
		endcase
		// End of string restarts the search
		if (s_tlast) begin
			phase_d  = PH_SEARCH;
			hi_nib_d = 4'd0;
		end
	end

	// Advance stream state on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SEARCH;
			hi_nib_q <= 4'd0;
			seen_q   <= '0;
		end else if (in_xfer) begin
			phase_q  <= phase_d;
			hi_nib_q <= hi_nib_d;
			if (s_tlast) begin
				seen_q <= '0;
			end else if (push && seen_q < LEN_W'(KEY_MAX)) begin
				seen_q <= seen_q + LEN_W'(1);
			end
		end
	end

	// Shift the window; entries beyond the seen count are never compared
	always_ff @(posedge clk) begin
		if (in_xfer && push) begin
			win_q[0] <= s_tdata;
			for (int i = 1; i < KEY_MAX; i++) begin
				win_q[i] <= win_q[i - 1];
			end
		end
	end

	// Queue writes
	assign n_wr = in_xfer ? ({1'b0, res_a_vld} + {1'b0, res_b_vld}) : 2'd0;

	always_ff @(posedge clk) begin
		if (in_xfer && res_a_vld) begin
			q_mem[wr_ptr_q] <= res_a;
		end
		if (in_xfer && res_b_vld) begin
			q_mem[wr_ptr_q + QPTR_W'(1)] <= res_b;
		end
	end

	// Queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QPTR_W'(n_wr);
			if (out_xfer) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			cnt_q <= cnt_q + QCNT_W'(n_wr) - QCNT_W'(out_xfer);
		end
	end

	// Accept while two entries are free
	assign s_tready = (cnt_q <= QCNT_W'(Q_DEPTH - 2));
	assign m_tvalid = (cnt_q != '0);
	assign m_tdata  = q_mem[rd_ptr_q].data;
	assign m_tuser  = q_mem[rd_ptr_q].status;
	assign m_tlast  = q_mem[rd_ptr_q].last;

	// Queue never overfills
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCNT_W'(Q_DEPTH))
		else $error("result queue over capacity");

	// Fill count follows writes and reads
	a_cnt_track: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> cnt_q == $past(cnt_q) + QCNT_W'($past(n_wr)) - QCNT_W'($past(out_xfer)))
		else $error("queue count mismatch");

	// End of string returns to search
	a_eos_restart: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && s_tlast |=> phase_q == PH_SEARCH && seen_q == '0)
		else $error("stream state not cleared at end of string");

	// Nothing is emitted after the value has ended until the string ends
	a_done_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && phase_q == PH_DONE |-> n_wr == 2'd0)
		else $error("result after value end");

	// A second result only closes the string
	a_second_last: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && res_b_vld |-> s_tlast && res_a.status == ST_BYTE)
		else $error("unexpected second result");

endmodule

/* tb/sv/qved_result_checker.sv */
// ----------------------------------------------------------------------------
// qved_result_checker
// Watches the key registers and both streams of the query value decoder,
// predicts every result and compares it field by field in arrival order.
// ----------------------------------------------------------------------------
module qved_result_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [qved_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [qved_pkg::KEYWORD_W-1:0] cfg_wdata,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	input  logic [7:0]                     s_tdata,   // [7:0] in_byte
	input  logic                           s_tlast,   // end_of_string
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic [7:0]                     m_tdata,   // [7:0] out_byte
	input  logic [1:0]                     m_tuser,   // [1:0] status
	input  logic                           m_tlast,   // last
	output int                             fail_count,
	output int                             pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import qved_pkg::*;

	// Key registers as the block should hold them
	logic [KEYLEN_W-1:0]  key_len;
	logic [KEYWORD_W-1:0] key_lo;
	logic [KEYWORD_W-1:0] key_hi;

	// Scan state: newest character in history[0]
	logic [BYTE_W-1:0]  history [KEY_CHARS];
	logic [PHASE_W-1:0] scan_phase;
	logic [3:0]         upper_nibble;
	int                 chars_seen;

	result_t expected_results[$];
	int      errors = 0;

	assign fail_count = errors;

	task automatic report(input string msg);
		$display("MISMATCH @%0t: %s", $realtime, msg);
		errors++;
	endtask

	function automatic logic [3:0] hex_digit(input logic [7:0] c);
		if (c >= "0" && c <= "9") begin
			return c[3:0];
		end
		if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) begin
			return c[3:0] + 4'd9;
		end
		return 4'd0;
	endfunction

	// Compare the newest characters with the key, oldest key character first
	function automatic bit key_in_history();
		int len;
		logic [7:0] kc;
		len = (key_len > KEY_CHARS) ? KEY_CHARS : int'(key_len);
		if (chars_seen < len) begin
			return 1'b0;
		end
		for (int i = 0; i < len; i++) begin
			kc = (i < 8) ? key_lo[8*i +: 8] : key_hi[8*(i-8) +: 8];
			if (history[len-1-i] != kc) begin
				return 1'b0;
			end
		end
		return 1'b1;
	endfunction

	task automatic shift_in(input logic [7:0] c);
		for (int i = KEY_CHARS - 1; i > 0; i--) begin
			history[i] = history[i-1];
		end
		history[0] = c;
		if (chars_seen < KEY_CHARS) begin
			chars_seen++;
		end
	endtask

	task automatic clear_scan();
		for (int i = 0; i < KEY_CHARS; i++) begin
			history[i] = '0;
		end
		scan_phase   = PH_SEARCH;
		upper_nibble = 4'd0;
		chars_seen   = 0;
	endtask

	task automatic expect_result(input logic [7:0] d, input logic [1:0] st, input logic lst);
		result_t r;
		r.data   = d;
		r.status = st;
		r.last   = lst;
		expected_results.push_back(r);
	endtask

	// Advance the scan by one character and queue what it yields
	task automatic decode_char(input logic [7:0] c, input logic eos);
		case (scan_phase)
			PH_SEARCH: begin
				if (c == CH_EQUAL && key_in_history()) begin
					scan_phase = PH_VALUE;
					if (eos) expect_result(8'h00, ST_COMPLETE, 1'b1);
				end else begin
					shift_in(c);
					if (eos) expect_result(8'h00, ST_NOKEY, 1'b1);
				end
			end
			PH_VALUE: begin
				if (c == CH_AMP) begin
					expect_result(8'h00, ST_COMPLETE, 1'b1);
					scan_phase = PH_DONE;
				end else if (c == CH_PERCENT) begin
					scan_phase = PH_ESC1;
					if (eos) expect_result(8'h00, ST_TRUNC, 1'b1);
				end else begin
					expect_result((c == CH_PLUS) ? CH_SPACE : c, ST_BYTE, 1'b0);
					if (eos) expect_result(8'h00, ST_COMPLETE, 1'b1);
				end
			end
			PH_ESC1: begin
				if (c == CH_AMP) begin
					expect_result(8'h00, ST_TRUNC, 1'b1);
					scan_phase = PH_DONE;
				end else begin
					upper_nibble = hex_digit(c);
					scan_phase   = PH_ESC2;
					if (eos) expect_result(8'h00, ST_TRUNC, 1'b1);
				end
			end
			PH_ESC2: begin
				if (c == CH_AMP) begin
					expect_result(8'h00, ST_TRUNC, 1'b1);
					scan_phase = PH_DONE;
				end else begin
					expect_result({upper_nibble, hex_digit(c)}, ST_BYTE, 1'b0);
					scan_phase = PH_VALUE;
					if (eos) expect_result(8'h00, ST_COMPLETE, 1'b1);
				end
			end
			default: begin
			end
		endcase
		if (eos) clear_scan();
	endtask

	task automatic check_result();
		result_t want;
		if (expected_results.size() == 0) begin
			report($sformatf("unexpected result data=%02h status=%0d last=%0b",
				m_tdata, m_tuser, m_tlast));
			return;
		end
		want = expected_results.pop_front();
		if (m_tdata != want.data)
			report($sformatf("out_byte %02h, expected %02h", m_tdata, want.data));
		if (m_tuser != want.status)
			report($sformatf("status %0d, expected %0d", m_tuser, want.status));
		if (m_tlast != want.last)
			report($sformatf("last %0b, expected %0b", m_tlast, want.last));
	endtask

	// Track registers, predict on each input transfer, check each output transfer
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_len = KEYLEN_W'(1);
			key_lo  = '0;
			key_hi  = '0;
			clear_scan();
			expected_results.delete();
			pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_KEY_LENGTH: key_len = cfg_wdata[KEYLEN_W-1:0];
					REG_KEY_LOW:    key_lo  = cfg_wdata;
					REG_KEY_HIGH:   key_hi  = cfg_wdata;
					default: begin
					end
				endcase
			end
			if (s_tvalid && s_tready) decode_char(s_tdata, s_tlast);
			if (m_tvalid && m_tready) check_result();
			pending <= expected_results.size();
		end
	end

endmodule

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Stimulus for the query value extract/decode block: directed query strings
// for each ending and escape case, then random strings built around a
// reprogrammed key, under several idle and backpressure mixes.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import qved_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int CHARS_PER_PHASE = 313;
	localparam int DRAIN_CYCLES    = 12;
	localparam int WATCHDOG_LIMIT  = 4000;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [KEYWORD_W-1:0] cfg_wdata = '0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [7:0]           s_tdata   = '0;
	logic                 s_tlast   = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [7:0]           m_tdata;
	logic [1:0]           m_tuser;
	logic                 m_tlast;

	int chk_fail;
	int chk_pending;

	int idle_pct  = 0;
	int stall_pct = 0;
	int chars_sent = 0;
	int quiet_cycles = 0;
	int key_used = 1;

	logic [7:0] key_text [KEY_CHARS];
	logic [7:0] query_q[$];

	int send_idle  [4] = '{0, 67, 0, 21};
	int recv_stall [4] = '{0, 0, 67, 21};

	always #1 clk = ~clk;

	query_value_extract_decode dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	qved_result_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast),
		.fail_count (chk_fail),
		.pending    (chk_pending)
	);

	// Stall the result stream at random
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	// Abort when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic logic [7:0] pick(input string s);
		return s[$urandom_range(s.len() - 1)];
	endfunction

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			query_q.push_back(s[i]);
		end
	endtask

	// Hold valid low for random gaps, then present one character until taken
	task automatic send_char(input logic [7:0] c, input logic eos);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		s_tlast  <= eos;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		chars_sent++;
	endtask

	task automatic send_query();
		for (int i = 0; i < query_q.size(); i++) begin
			send_char(query_q[i], i == query_q.size() - 1);
		end
		query_q.delete();
	endtask

	// Stop sending and wait until every expected result has come out
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (chk_pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write all key registers back to back while the block is idle
	task automatic program_key(input int len);
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] lw;
		for (int i = 0; i < 8; i++) begin
			lo[8*i +: 8] = key_text[i];
			hi[8*i +: 8] = key_text[8+i];
		end
		lw = {$urandom(), $urandom()};
		lw[KEYLEN_W-1:0] = len[KEYLEN_W-1:0];
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= REG_KEY_LENGTH;
		cfg_wdata <= lw;
		@(posedge clk);
		cfg_index <= REG_KEY_LOW;
		cfg_wdata <= lo;
		@(posedge clk);
		cfg_index <= REG_KEY_HIGH;
		cfg_wdata <= hi;
		@(posedge clk);
		if ($urandom_range(1)) begin
			cfg_index <= REG_UNUSED;
			cfg_wdata <= {$urandom(), $urandom()};
			@(posedge clk);
		end
		cfg_we   <= 1'b0;
		key_used = (len > KEY_CHARS) ? KEY_CHARS : len;
	endtask

	// Pick a key: mostly short over a tiny alphabet, sometimes an extreme length
	task automatic random_key();
		int roll;
		int len;
		roll = $urandom_range(99);
		if (roll < 5)       len = 0;
		else if (roll < 10) len = KEY_CHARS;
		else if (roll < 14) len = $urandom_range(30, KEY_CHARS + 1);
		else if (roll < 17) len = 31;
		else                len = $urandom_range(6, 1);
		for (int i = 0; i < KEY_CHARS; i++) begin
			key_text[i] = 8'($urandom_range(255));
			if (i < len && $urandom_range(99) < 80) key_text[i] = pick("abc");
		end
		program_key(len);
	endtask

	task automatic add_noise(input int n);
		repeat (n) begin
			if ($urandom_range(1)) query_q.push_back(8'($urandom_range(255)));
			else query_q.push_back(pick("abc=&%+"));
		end
	endtask

	// Value text: plain characters, plus signs and escapes with odd digits now and then
	task automatic add_value();
		int pieces;
		int roll;
		logic [7:0] c;
		pieces = $urandom_range(5);
		repeat (pieces) begin
			roll = $urandom_range(99);
			if (roll < 55) begin
				c = pick("abcxyz019-._");
				if ($urandom_range(4) == 0) c = 8'($urandom_range(255));
				if (c == CH_AMP || c == CH_PERCENT) c = "z";
				query_q.push_back(c);
			end else if (roll < 75) begin
				query_q.push_back(CH_PLUS);
			end else begin
				query_q.push_back(CH_PERCENT);
				repeat (2) begin
					c = pick("0123456789abcdefABCDEF");
					if ($urandom_range(6) == 0) c = 8'($urandom_range(255));
					if (c == CH_AMP) c = "G";
					query_q.push_back(c);
				end
			end
		end
	endtask

	task automatic build_query();
		int roll;
		if ($urandom_range(99) < 25) begin
			add_noise($urandom_range(12, 1));
			return;
		end
		if ($urandom_range(2) == 0) add_noise($urandom_range(4, 1));
		// leading parameters that may partly resemble the key
		repeat ($urandom_range(2)) begin
			repeat ($urandom_range(4, 1)) query_q.push_back(pick("abc"));
			query_q.push_back(CH_EQUAL);
			repeat ($urandom_range(3)) query_q.push_back(pick("abcxyz"));
			query_q.push_back(CH_AMP);
		end
		for (int i = 0; i < key_used; i++) begin
			query_q.push_back(key_text[i]);
		end
		query_q.push_back(CH_EQUAL);
		add_value();
		roll = $urandom_range(99);
		if (roll < 40) begin
			// value runs to the end of the string
		end else if (roll < 80) begin
			query_q.push_back(CH_AMP);
			add_noise($urandom_range(4));
		end else begin
			// escape cut short
			query_q.push_back(CH_PERCENT);
			if ($urandom_range(1)) query_q.push_back(pick("0123456789abcdef"));
			if ($urandom_range(1)) query_q.push_back(CH_AMP);
		end
	endtask

	initial begin
		int strings;
		int start;
		for (int i = 0; i < KEY_CHARS; i++) begin
			key_text[i] = '0;
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed strings with key "ab"
		key_text[0] = "a";
		key_text[1] = "b";
		program_key(2);
		push_text("ab=");
		send_query();
		push_text("xab=");
		query_q.push_back(8'hFF);
		query_q.push_back(8'h00);
		push_text("+%4a&");
		send_query();
		push_text("ab=%4&x");
		send_query();
		push_text("q");
		send_query();
		// empty key: first '=' matches, escape cut by the end of the string
		program_key(0);
		push_text("=%g");
		send_query();

		// Random strings under each idle and stall mix
		for (int p = 0; p < 4; p++) begin
			idle_pct  = send_idle[p];
			stall_pct = recv_stall[p];
			strings   = 0;
			start     = chars_sent;
			while (chars_sent - start < CHARS_PER_PHASE) begin
				if (strings % 4 == 0) random_key();
				build_query();
				send_query();
				strings++;
			end
		end

		drain();
		if (chk_fail == 0 && chk_pending == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
